/* rtl/core/tdh_pkg.sv */
package tdh_pkg;

	// Largest year accepted in a stamp
	localparam int unsigned MAX_YEAR = 9999;

	// Field widths
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned SEC_W   = 6;
	localparam int unsigned HOURS_W = 27;

	// Internal widths
	localparam int unsigned DAYS_W  = 23;  // day count up to the largest 14-bit year
	localparam int unsigned TOD_W   = 17;  // seconds of day
	localparam int unsigned MOFF_W  = 9;   // days before month incl. leap day
	localparam int unsigned QY_W    = 8;   // (year-1)/100
	localparam int unsigned REM_W   = 12;  // seconds within an hour

	// Calendar constants
	localparam int unsigned SECS_PER_DAY  = 86400;
	localparam int unsigned SECS_PER_HOUR = 3600;
	localparam int unsigned SECS_PER_MIN  = 60;
	localparam int unsigned DAYS_PER_YEAR = 365;

	// Reciprocals for constant division (exact over the value ranges used)
	localparam int unsigned RECIP_100   = 5243;   // x/100  = (x*RECIP) >> 19, x < 43690
	localparam int unsigned SHIFT_100   = 19;
	localparam int unsigned RECIP_3600  = 37283;  // x/3600 = (x*RECIP) >> 27, x < 125203
	localparam int unsigned SHIFT_3600  = 27;
	localparam int unsigned RECIP_60    = 4370;   // x/60   = (x*RECIP) >> 18, x < 4681
	localparam int unsigned SHIFT_60    = 18;

	// Month codes
	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	typedef struct packed {
		logic [YEAR_W-1:0]  first_year;
		logic [MONTH_W-1:0] first_month;
		logic [DAY_W-1:0]   first_day;
		logic [HOUR_W-1:0]  first_hour;
		logic [MIN_W-1:0]   first_minute;
		logic [SEC_W-1:0]   first_second;
		logic [YEAR_W-1:0]  second_year;
		logic [MONTH_W-1:0] second_month;
		logic [DAY_W-1:0]   second_day;
		logic [HOUR_W-1:0]  second_hour;
		logic [MIN_W-1:0]   second_minute;
		logic [SEC_W-1:0]   second_sec;
	} stamp_word_t;

	typedef struct packed {
		logic [HOURS_W-1:0] diff_hours;
		logic [MIN_W-1:0]   diff_minutes;
		logic [SEC_W-1:0]   diff_seconds;
		logic               invalid;
	} result_word_t;

	// Per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic s8;
	} stage_en_t;

	// Days in whole months before the given month, common year
	function automatic logic [MOFF_W-1:0] days_before(input logic [MONTH_W-1:0] mo);
		logic [MOFF_W-1:0] r;
		case (mo)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Length of the given month
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo,
		input logic leap);
		logic [DAY_W-1:0] r;
		case (mo)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
			4'd2:    r = leap ? 5'd29 : 5'd28;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/tdh_stamp.sv */
// One stamp to (valid, day count, seconds of day) over stages 1 to 3
module tdh_stamp #(
	parameter int unsigned MAX_YEAR = tdh_pkg::MAX_YEAR
) (
	input  logic                          clk,
	input  tdh_pkg::stage_en_t            en,
	input  logic [tdh_pkg::YEAR_W-1:0]    year,
	input  logic [tdh_pkg::MONTH_W-1:0]   month,
	input  logic [tdh_pkg::DAY_W-1:0]     day,
	input  logic [tdh_pkg::HOUR_W-1:0]    hour,
	input  logic [tdh_pkg::MIN_W-1:0]     minute,
	input  logic [tdh_pkg::SEC_W-1:0]     second,
	output logic                          ok_s3,
	output logic [tdh_pkg::DAYS_W-1:0]    days_s3,
	output logic [tdh_pkg::TOD_W-1:0]     tod_s3
);

	localparam int unsigned PROD_W = tdh_pkg::YEAR_W + 13;

	// stage 1 registers
	logic [tdh_pkg::YEAR_W-1:0]  py_s1;
	logic [PROD_W-1:0]           prod_s1;
	logic                        year_ok_s1;
	logic                        hms_ok_s1;
	logic [tdh_pkg::MONTH_W-1:0] mo_s1;
	logic [tdh_pkg::DAY_W-1:0]   day_s1;
	logic [tdh_pkg::TOD_W-1:0]   tod_s1;

	// stage 2 registers
	logic                        ok_s2;
	logic [tdh_pkg::DAYS_W-1:0]  dyear_s2;
	logic [tdh_pkg::MOFF_W-1:0]  moff_s2;
	logic [tdh_pkg::DAY_W-1:0]   day_s2;
	logic [tdh_pkg::TOD_W-1:0]   tod_s2;

	// stage 2 logic
	logic [tdh_pkg::QY_W-1:0]    qy;
	logic [6:0]                  ry;
	logic                        leap;
	logic [tdh_pkg::DAY_W-1:0]   lim;
	logic [tdh_pkg::YEAR_W-1:0]  qy100;

	// Stage 1: range checks, previous year, reciprocal product, time of day
	always_ff @(posedge clk) begin
		if (en.s1) begin
			py_s1      <= year - tdh_pkg::YEAR_W'(1);
			prod_s1    <= PROD_W'(year - tdh_pkg::YEAR_W'(1)) * PROD_W'(tdh_pkg::RECIP_100);
			year_ok_s1 <= (year != '0) &&
			              (17'(year) <= 17'(MAX_YEAR));
			hms_ok_s1  <= (month >= tdh_pkg::MON_JAN) && (month <= tdh_pkg::MON_DEC) &&
			              (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59);
			mo_s1      <= month;
			day_s1     <= day;
			tod_s1     <= tdh_pkg::TOD_W'(hour) * tdh_pkg::TOD_W'(tdh_pkg::SECS_PER_HOUR) +
			              tdh_pkg::TOD_W'(minute) * tdh_pkg::TOD_W'(tdh_pkg::SECS_PER_MIN) +
			              tdh_pkg::TOD_W'(second);
		end
	end

	// Leap test from py = year-1: year%4==0 <=> py%4==3, year%100==0 <=> py%100==99
	always_comb begin
		qy    = prod_s1[tdh_pkg::SHIFT_100 +: tdh_pkg::QY_W];
		qy100 = tdh_pkg::YEAR_W'(qy) * tdh_pkg::YEAR_W'(100);
		ry    = 7'(py_s1 - qy100);
		leap  = (py_s1[1:0] == 2'b11) && ((ry != 7'd99) || (qy[1:0] == 2'b11));
		lim   = tdh_pkg::month_len(mo_s1, leap);
	end

	// Stage 2: day check, days in whole years, month offset
	always_ff @(posedge clk) begin
		if (en.s2) begin
			ok_s2    <= year_ok_s1 && hms_ok_s1 && (day_s1 != '0) && (day_s1 <= lim);
			dyear_s2 <= tdh_pkg::DAYS_W'(py_s1) * tdh_pkg::DAYS_W'(tdh_pkg::DAYS_PER_YEAR) +
			            tdh_pkg::DAYS_W'(py_s1 >> 2) - tdh_pkg::DAYS_W'(qy) +
			            tdh_pkg::DAYS_W'(qy >> 2);
			moff_s2  <= tdh_pkg::days_before(mo_s1) +
			            tdh_pkg::MOFF_W'(leap && (mo_s1 > tdh_pkg::MON_FEB));
			day_s2   <= day_s1;
			tod_s2   <= tod_s1;
		end
	end

	// Stage 3: full day count
	always_ff @(posedge clk) begin
		if (en.s3) begin
			ok_s3   <= ok_s2;
			days_s3 <= dyear_s2 + tdh_pkg::DAYS_W'(moff_s2) + tdh_pkg::DAYS_W'(day_s2) -
			           tdh_pkg::DAYS_W'(1);
			tod_s3  <= tod_s2;
		end
	end

endmodule

/* rtl/core/tdh_diff.sv */
// Absolute difference of two (days, seconds of day) pairs, split to h/m/s, stages 4 to 8
module tdh_diff (
	input  logic                          clk,
	input  tdh_pkg::stage_en_t            en,
	input  logic                          a_ok,
	input  logic [tdh_pkg::DAYS_W-1:0]    a_days,
	input  logic [tdh_pkg::TOD_W-1:0]     a_tod,
	input  logic                          b_ok,
	input  logic [tdh_pkg::DAYS_W-1:0]    b_days,
	input  logic [tdh_pkg::TOD_W-1:0]     b_tod,
	output tdh_pkg::result_word_t         result_s8
);

	localparam int unsigned HPROD_W = 32;
	localparam int unsigned MPROD_W = 24;
	localparam int unsigned HQ_W    = 5;
	localparam int unsigned DH_W    = tdh_pkg::HOURS_W + 1;

	// stage 4
	logic                              ok_s4;
	logic [tdh_pkg::DAYS_W-1:0]        dd_s4;
	logic signed [tdh_pkg::TOD_W:0]    td_s4;
	// stage 5
	logic                              ok_s5;
	logic [tdh_pkg::DAYS_W-1:0]        dd_s5;
	logic [tdh_pkg::TOD_W-1:0]         td_s5;
	// stage 6
	logic                              ok_s6;
	logic [DH_W-1:0]                   dh_s6;
	logic [tdh_pkg::TOD_W-1:0]         td_s6;
	logic [HPROD_W-1:0]                hprod_s6;
	// stage 7
	logic                              ok_s7;
	logic [tdh_pkg::HOURS_W-1:0]       hours_s7;
	logic [tdh_pkg::REM_W-1:0]         rem_s7;
	logic [MPROD_W-1:0]                mprod_s7;

	logic                              a_ge;
	logic [tdh_pkg::DAYS_W-1:0]        big_days, sml_days;
	logic [tdh_pkg::TOD_W-1:0]         big_tod, sml_tod;
	logic [HQ_W-1:0]                   hq;
	logic [tdh_pkg::TOD_W-1:0]         hq_secs;
	logic [tdh_pkg::MIN_W-1:0]         mq;
	logic [tdh_pkg::REM_W-1:0]         mq_secs;

	// Order the stamps; seconds of day stay below a day, so compare days first
	always_comb begin
		a_ge     = (a_days > b_days) || ((a_days == b_days) && (a_tod >= b_tod));
		big_days = a_ge ? a_days : b_days;
		sml_days = a_ge ? b_days : a_days;
		big_tod  = a_ge ? a_tod : b_tod;
		sml_tod  = a_ge ? b_tod : a_tod;
	end

	// Stage 4: day and second differences, second part may be negative
	always_ff @(posedge clk) begin
		if (en.s4) begin
			ok_s4 <= a_ok && b_ok;
			dd_s4 <= big_days - sml_days;
			td_s4 <= $signed({1'b0, big_tod}) - $signed({1'b0, sml_tod});
		end
	end

	// Stage 5: borrow a day when the second part is negative
	always_ff @(posedge clk) begin
		if (en.s5) begin
			ok_s5 <= ok_s4;
			if (td_s4[tdh_pkg::TOD_W]) begin
				dd_s5 <= dd_s4 - tdh_pkg::DAYS_W'(1);
				td_s5 <= tdh_pkg::TOD_W'(td_s4[tdh_pkg::TOD_W-1:0] +
				         tdh_pkg::TOD_W'(tdh_pkg::SECS_PER_DAY));
			end else begin
				dd_s5 <= dd_s4;
				td_s5 <= td_s4[tdh_pkg::TOD_W-1:0];
			end
		end
	end

	// Stage 6: hours from whole days, reciprocal product for seconds / 3600
	always_ff @(posedge clk) begin
		if (en.s6) begin
			ok_s6    <= ok_s5;
			dh_s6    <= (DH_W'(dd_s5) << 4) + (DH_W'(dd_s5) << 3);
			td_s6    <= td_s5;
			hprod_s6 <= HPROD_W'(td_s5) * HPROD_W'(tdh_pkg::RECIP_3600);
		end
	end

	assign hq      = hprod_s6[tdh_pkg::SHIFT_3600 +: HQ_W];
	assign hq_secs = tdh_pkg::TOD_W'(hq) * tdh_pkg::TOD_W'(tdh_pkg::SECS_PER_HOUR);

	// Stage 7: total hours (kept to the field width), remainder, product for / 60
	always_ff @(posedge clk) begin
		if (en.s7) begin
			ok_s7    <= ok_s6;
			hours_s7 <= tdh_pkg::HOURS_W'(dh_s6 + DH_W'(hq));
			rem_s7   <= tdh_pkg::REM_W'(td_s6 - hq_secs);
			mprod_s7 <= MPROD_W'(tdh_pkg::REM_W'(td_s6 - hq_secs)) *
			            MPROD_W'(tdh_pkg::RECIP_60);
		end
	end

	assign mq      = mprod_s7[tdh_pkg::SHIFT_60 +: tdh_pkg::MIN_W];
	assign mq_secs = tdh_pkg::REM_W'(mq) * tdh_pkg::REM_W'(tdh_pkg::SECS_PER_MIN);

	// Stage 8: output word; zero fields and invalid set when either stamp failed its checks
	always_ff @(posedge clk) begin
		if (en.s8) begin
			if (ok_s7) begin
				result_s8.diff_hours   <= hours_s7;
				result_s8.diff_minutes <= mq;
				result_s8.diff_seconds <= tdh_pkg::SEC_W'(rem_s7 - mq_secs);
				result_s8.invalid      <= 1'b0;
			end else begin
				result_s8.diff_hours   <= '0;
				result_s8.diff_minutes <= '0;
				result_s8.diff_seconds <= '0;
				result_s8.invalid      <= 1'b1;
			end
		end
	end

endmodule

/* rtl/core/timestamp_difference_hms_unit.sv */
// Channel  | valid          | stall          | payload
// ---------+----------------+----------------+-----------------------------
// stamps   | stamp_valid    | stamp_stall    | stamp_word  (stamp_word_t)
// result   | result_valid   | result_stall   | result_word (result_word_t)
//
// Eight register stages; a word enters every cycle while stamp_stall is low,
// and its result leaves the last stage on result_word.
// arst_n clears the stage valid bits only; data registers are not reset.
// A stage loads whenever it is empty or the stage after it moves, so
// bubbles collapse under result_stall and new words are taken while they last.
module timestamp_difference_hms_unit #(
	parameter int unsigned MAX_YEAR = tdh_pkg::MAX_YEAR
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  stamp_valid,
	output logic                  stamp_stall,
	input  tdh_pkg::stamp_word_t  stamp_word,
	output logic                  result_valid,
	input  logic                  result_stall,
	output tdh_pkg::result_word_t result_word
);

	localparam int unsigned STAGES = 8;

	logic [STAGES:1]              v_q;
	logic [STAGES:1]              rdy;
	tdh_pkg::stage_en_t           en;

	logic                         a_ok_s3, b_ok_s3;
	logic [tdh_pkg::DAYS_W-1:0]   a_days_s3, b_days_s3;
	logic [tdh_pkg::TOD_W-1:0]    a_tod_s3, b_tod_s3;

	// Ready chain from the output back to the input
	always_comb begin
		rdy[STAGES] = !v_q[STAGES] || !result_stall;
		for (int k = STAGES - 1; k >= 1; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
		en.s1 = rdy[1];
		en.s2 = rdy[2];
		en.s3 = rdy[3];
		en.s4 = rdy[4];
		en.s5 = rdy[5];
		en.s6 = rdy[6];
		en.s7 = rdy[7];
		en.s8 = rdy[8];
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[1]) begin
				v_q[1] <= stamp_valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign stamp_stall  = !rdy[1];
	assign result_valid = v_q[STAGES];

	tdh_stamp #(
		.MAX_YEAR (MAX_YEAR)
	) u_stamp_a (
		.clk     (clk),
		.en      (en),
		.year    (stamp_word.first_year),
		.month   (stamp_word.first_month),
		.day     (stamp_word.first_day),
		.hour    (stamp_word.first_hour),
		.minute  (stamp_word.first_minute),
		.second  (stamp_word.first_second),
		.ok_s3   (a_ok_s3),
		.days_s3 (a_days_s3),
		.tod_s3  (a_tod_s3)
	);

	tdh_stamp #(
		.MAX_YEAR (MAX_YEAR)
	) u_stamp_b (
		.clk     (clk),
		.en      (en),
		.year    (stamp_word.second_year),
		.month   (stamp_word.second_month),
		.day     (stamp_word.second_day),
		.hour    (stamp_word.second_hour),
		.minute  (stamp_word.second_minute),
		.second  (stamp_word.second_sec),
		.ok_s3   (b_ok_s3),
		.days_s3 (b_days_s3),
		.tod_s3  (b_tod_s3)
	);

	tdh_diff u_diff (
		.clk       (clk),
		.en        (en),
		.a_ok      (a_ok_s3),
		.a_days    (a_days_s3),
		.a_tod     (a_tod_s3),
		.b_ok      (b_ok_s3),
		.b_days    (b_days_s3),
		.b_tod     (b_tod_s3),
		.result_s8 (result_word)
	);

endmodule
